### rtl/id_pool_free_list_allocator_core_macros.svh
// assertion macros shared by the id pool allocator checkers
// no dependencies; the asserting file must have i_clk and i_rst_n in scope
`ifndef ID_POOL_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define ID_POOL_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// generic clocked assertion with an explicit clock and active-low reset
`define IDPA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// assertion on the block clock and reset
`define IDPA_ASSERT(label, prop, msg) \
    `IDPA_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### rtl/idpa_pkg.sv
// types, constants and control structs of the id pool allocator
// no dependencies
`default_nettype none

package idpa_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int ID_W      = $clog2(POOL_SIZE);
    localparam int LINK_W    = $clog2(POOL_SIZE + 1);
    localparam int ARG_W     = 11;
    localparam int CFG_W     = 10;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_SIZE);

    // register index taken from the word address
    localparam logic REG_FIRST_ID = 1'b0;
    localparam logic REG_LAST_ID  = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_BULK  = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_FREE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_BULK,
        ST_CHECK,
        ST_SEAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic init_setup;
        logic sweep;
        logic sweep_links;
        logic rd_en;
        logic rd_head;
        logic bulk_setup;
        logic unlink;
        logic append;
        logic seal;
        logic set_applied;
        logic applied_val;
        logic out_load;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic id_ok;
        logic bulk_ok;
        logic rem_zero;
        logic head_end;
        logic used;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/idpa_if.sv
// request and result channel interfaces of the id pool allocator
// depends on idpa_pkg
`default_nettype none

interface idpa_req_if;
    import idpa_pkg::*;
    logic             valid;
    logic             ready;
    t_cmd             command;
    logic [ARG_W-1:0] arg;

    modport source (output valid, command, arg, input ready);
    modport sink   (input valid, command, arg, output ready);
endinterface

interface idpa_rsp_if;
    import idpa_pkg::*;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   head_id;
    logic [LINK_W-1:0] free_count;
    logic              applied;

    modport source (output valid, head_id, free_count, applied, input ready);
    modport sink   (input valid, head_id, free_count, applied, output ready);
endinterface

`default_nettype wire

### rtl/idpa_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module idpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/idpa_dp.sv
// datapath: link memories, used marks, head/tail/count and result register
// depends on idpa_pkg and idpa_ram
`default_nettype none

module idpa_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire idpa_pkg::t_dp_ctl        i_ctl,
    output idpa_pkg::t_dp_sts             o_sts,
    input  wire logic [idpa_pkg::CFG_W-1:0] i_first,
    input  wire logic [idpa_pkg::CFG_W-1:0] i_last,
    input  wire idpa_pkg::t_cmd           i_req_command,
    input  wire logic [idpa_pkg::ARG_W-1:0] i_req_arg,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic [idpa_pkg::ID_W-1:0]     o_head_id,
    output logic [idpa_pkg::LINK_W-1:0]   o_free_count,
    output logic                          o_applied
);

    import idpa_pkg::*;

    t_cmd              r_cmd;
    logic [ARG_W-1:0]  r_arg;
    logic [LINK_W-1:0] r_head;
    logic [LINK_W-1:0] r_tail;
    logic [LINK_W-1:0] r_free;
    logic [LINK_W-1:0] r_rem;
    logic [ID_W-1:0]   r_idx;
    logic [ID_W-1:0]   r_tgt;
    logic              r_applied;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_head;
    logic [LINK_W-1:0] r_out_free;
    logic              r_out_applied;

    logic [LINK_W-1:0] w_first;
    logic [LINK_W-1:0] w_last;
    logic [LINK_W-1:0] w_hi;
    logic [LINK_W-1:0] w_idx;
    logic [LINK_W-1:0] w_tgt;
    logic              w_in_init;
    logic [ID_W-1:0]   w_raddr;

    logic [LINK_W-1:0] w_nxt_q;
    logic [LINK_W-1:0] w_prv_q;
    logic [0:0]        w_use_q;

    logic              w_nxt_we;
    logic [ID_W-1:0]   w_nxt_wa;
    logic [LINK_W-1:0] w_nxt_wd;
    logic              w_prv_we;
    logic [ID_W-1:0]   w_prv_wa;
    logic [LINK_W-1:0] w_prv_wd;
    logic              w_use_we;
    logic [ID_W-1:0]   w_use_wa;
    logic [0:0]        w_use_wd;

    assign w_first   = LINK_W'(i_first);
    assign w_last    = LINK_W'(i_last);
    // ids at or above the pool size are never linked
    assign w_hi      = (w_last < END_MARK) ? w_last : END_MARK - 1'b1;
    assign w_idx     = LINK_W'(r_idx);
    assign w_tgt     = LINK_W'(r_tgt);
    assign w_in_init = (w_idx >= w_first) && (w_idx <= w_hi);
    assign w_raddr   = i_ctl.rd_head ? r_head[ID_W-1:0] : r_arg[ID_W-1:0];

    idpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nxt_we),
        .i_waddr (w_nxt_wa),
        .i_wdata (w_nxt_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_nxt_q)
    );

    idpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prv_we),
        .i_waddr (w_prv_wa),
        .i_wdata (w_prv_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_prv_q)
    );

    idpa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_use_we),
        .i_waddr (w_use_wa),
        .i_wdata (w_use_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_use_q)
    );

    // memory write steering, one write per ram per cycle
    always_comb begin
        w_nxt_we = 1'b0;
        w_nxt_wa = r_tgt;
        w_nxt_wd = END_MARK;
        w_prv_we = 1'b0;
        w_prv_wa = r_tgt;
        w_prv_wd = END_MARK;
        w_use_we = 1'b0;
        w_use_wa = r_tgt;
        w_use_wd = 1'b0;
        if (i_ctl.sweep) begin
            w_use_we = 1'b1;
            w_use_wa = r_idx;
            w_use_wd = 1'b0;
            if (i_ctl.sweep_links && w_in_init) begin
                w_nxt_we = 1'b1;
                w_nxt_wa = r_idx;
                w_nxt_wd = (w_idx == w_hi) ? END_MARK : w_idx + 1'b1;
                w_prv_we = 1'b1;
                w_prv_wa = r_idx;
                w_prv_wd = (w_idx == w_first) ? END_MARK : w_idx - 1'b1;
            end
        end
        if (i_ctl.unlink) begin
            // bridge predecessor and successor; end-mark targets are dropped
            w_nxt_we = (w_prv_q < END_MARK);
            w_nxt_wa = w_prv_q[ID_W-1:0];
            w_nxt_wd = w_nxt_q;
            w_prv_we = (w_nxt_q < END_MARK);
            w_prv_wa = w_nxt_q[ID_W-1:0];
            w_prv_wd = w_prv_q;
            w_use_we = 1'b1;
            w_use_wa = r_tgt;
            w_use_wd = 1'b1;
        end
        if (i_ctl.append) begin
            w_use_we = 1'b1;
            w_use_wa = r_tgt;
            w_use_wd = 1'b0;
            w_prv_we = 1'b1;
            w_prv_wa = r_tgt;
            w_prv_wd = (r_free == '0) ? END_MARK : r_tail;
            w_nxt_we = (r_free != '0) && (r_tail < END_MARK);
            w_nxt_wa = r_tail[ID_W-1:0];
            w_nxt_wd = w_tgt;
        end
        if (i_ctl.seal) begin
            w_nxt_we = 1'b1;
            w_nxt_wa = r_tgt;
            w_nxt_wd = END_MARK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= '0;
            r_rem       <= '0;
            r_idx       <= '0;
            r_applied   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.init_setup) begin
                r_head <= w_first;
                r_tail <= w_hi;
                r_free <= (w_first > w_hi) ? '0 : w_hi - w_first + 1'b1;
                r_idx  <= '0;
            end
            if (i_ctl.sweep) begin
                r_idx <= (r_idx == ID_W'(POOL_SIZE - 1)) ? '0 : r_idx + 1'b1;
            end
            if (i_ctl.bulk_setup) begin
                r_rem <= LINK_W'(r_arg);
            end
            if (i_ctl.unlink) begin
                if (w_tgt == r_head) begin
                    r_head <= w_nxt_q;
                end
                if (w_tgt == r_tail) begin
                    r_tail <= w_prv_q;
                end
                if (r_free != '0) begin
                    r_free <= r_free - 1'b1;
                end
                if (r_rem != '0) begin
                    r_rem <= r_rem - 1'b1;
                end
            end
            if (i_ctl.append) begin
                if (r_free == '0) begin
                    r_head <= w_tgt;
                end
                r_tail <= w_tgt;
                if (r_free < END_MARK) begin
                    r_free <= r_free + 1'b1;
                end
            end
            if (i_ctl.set_applied) begin
                r_applied <= i_ctl.applied_val;
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_req) begin
            r_cmd <= i_req_command;
            r_arg <= i_req_arg;
        end
        if (i_ctl.rd_en) begin
            r_tgt <= w_raddr;
        end
        if (i_ctl.out_load) begin
            // empty list reports head zero
            r_out_head    <= (r_free == '0) ? '0 : r_head[ID_W-1:0];
            r_out_free    <= r_free;
            r_out_applied <= r_applied;
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.id_ok      = (r_arg >= ARG_W'(i_first)) && (r_arg <= ARG_W'(i_last))
                           && (r_arg < ARG_W'(POOL_SIZE));
        o_sts.bulk_ok    = (r_arg <= ARG_W'(r_free));
        o_sts.rem_zero   = (r_rem == '0);
        o_sts.head_end   = (r_head >= END_MARK);
        o_sts.used       = w_use_q[0];
        o_sts.sweep_last = (r_idx == ID_W'(POOL_SIZE - 1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_head_id    = r_out_head;
    assign o_free_count = r_out_free;
    assign o_applied    = r_out_applied;

endmodule

`default_nettype wire

### rtl/idpa_ctrl.sv
// controller state machine sequencing the allocator datapath
// depends on idpa_pkg
`default_nettype none

module idpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire idpa_pkg::t_dp_sts i_sts,
    output idpa_pkg::t_dp_ctl      o_ctl
);

    import idpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                // used marks swept to zero after reset
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.load_req = 1'b1;
                    n_state        = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.cmd) inside
                    CMD_INIT: begin
                        o_ctl.init_setup  = 1'b1;
                        o_ctl.set_applied = 1'b1;
                        o_ctl.applied_val = 1'b1;
                        n_state           = ST_SWEEP;
                    end
                    CMD_BULK: begin
                        o_ctl.set_applied = 1'b1;
                        if (i_sts.bulk_ok) begin
                            o_ctl.applied_val = 1'b1;
                            o_ctl.bulk_setup  = 1'b1;
                            n_state           = ST_BULK;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    CMD_ALLOC, CMD_FREE: begin
                        if (i_sts.id_ok) begin
                            o_ctl.rd_en = 1'b1;
                            n_state     = ST_CHECK;
                        end else begin
                            o_ctl.set_applied = 1'b1;
                            n_state           = ST_DONE;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_SWEEP: begin
                o_ctl.sweep       = 1'b1;
                o_ctl.sweep_links = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_BULK: begin
                if (i_sts.rem_zero || i_sts.head_end) begin
                    n_state = ST_DONE;
                end else begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_head = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                unique case (i_sts.cmd)
                    CMD_BULK: begin
                        o_ctl.unlink = 1'b1;
                        n_state      = ST_BULK;
                    end
                    CMD_ALLOC: begin
                        o_ctl.set_applied = 1'b1;
                        if (!i_sts.used) begin
                            o_ctl.unlink      = 1'b1;
                            o_ctl.applied_val = 1'b1;
                        end
                        n_state = ST_DONE;
                    end
                    CMD_FREE: begin
                        o_ctl.set_applied = 1'b1;
                        if (i_sts.used) begin
                            o_ctl.append      = 1'b1;
                            o_ctl.applied_val = 1'b1;
                            n_state           = ST_SEAL;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_SEAL: begin
                // new tail gets the end mark as its next link
                o_ctl.seal = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/id_pool_free_list_allocator_core.sv
// id pool allocator top: apb range registers, controller and datapath.
// allocate: decode, then check (used mark read, unlink), then the result is loaded.
// free: decode, check (append), seal, then result. bulk of n: n unlink rounds.
// init: one link-memory entry per cycle over the pool.
// after reset a pass over the pool clears the used marks; requests wait for it.
`default_nettype none

module id_pool_free_list_allocator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    idpa_req_if.sink                         i_req,
    idpa_rsp_if.source                       o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [idpa_pkg::APB_AW-1:0] paddr,
    input  wire logic [idpa_pkg::APB_DW-1:0] pwdata,
    output logic      [idpa_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    import idpa_pkg::*;

    logic [CFG_W-1:0] r_first_id;
    logic [CFG_W-1:0] r_last_id;
    logic             w_wr;
    logic             w_reg_idx;
    t_dp_ctl          w_ctl;
    t_dp_sts          w_sts;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id <= '0;
            r_last_id  <= '1;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_FIRST_ID: r_first_id <= pwdata[CFG_W-1:0];
                REG_LAST_ID:  r_last_id  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_FIRST_ID: prdata = APB_DW'(r_first_id);
            REG_LAST_ID:  prdata = APB_DW'(r_last_id);
            default:      prdata = '0;
        endcase
    end

    idpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    idpa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_first       (r_first_id),
        .i_last        (r_last_id),
        .i_req_command (i_req.command),
        .i_req_arg     (i_req.arg),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_head_id     (o_rsp.head_id),
        .o_free_count  (o_rsp.free_count),
        .o_applied     (o_rsp.applied)
    );

endmodule

`default_nettype wire

### rtl/idpa_chk.sv
// port-level checker for the id pool allocator, bound to the top level
// depends on idpa_pkg and the assertion macro header
`default_nettype none
`include "id_pool_free_list_allocator_core_macros.svh"

module idpa_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [idpa_pkg::ID_W-1:0]     i_head_id,
    input wire logic [idpa_pkg::LINK_W-1:0]   i_free_count,
    input wire logic                          i_applied
);

    import idpa_pkg::*;

    // one request in flight at a time
    `IDPA_ASSERT(a_one_in_flight, (i_req_valid && i_req_ready) |=> !i_req_ready, "request accepted while busy")

    // results are only loaded while no request can be taken
    `IDPA_ASSERT(a_result_after_work, $rose(i_rsp_valid) |-> !$past(i_req_ready), "result appeared without work")

    `IDPA_ASSERT(a_count_bound, i_rsp_valid |-> (i_free_count <= END_MARK), "free count above pool size")

    `IDPA_ASSERT(a_empty_head, (i_rsp_valid && (i_free_count == '0)) |-> (i_head_id == '0), "empty list head not zero")

    `IDPA_ASSERT(a_rsp_hold, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_head_id) && $stable(i_free_count) && $stable(i_applied)), "stalled result changed")

endmodule

bind id_pool_free_list_allocator_core idpa_chk u_idpa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_head_id    (o_rsp.head_id),
    .i_free_count (o_rsp.free_count),
    .i_applied    (o_rsp.applied)
);

`default_nettype wire

### test/id_pool_free_list_allocator_core_test.sv
// testbench for the id pool allocator: directed and random requests checked against
// a free list tracker kept in a small scoreboard class
// depends on idpa_pkg, idpa_if and the id_pool_free_list_allocator_core rtl
`timescale 1ns / 1ps

package idpa_test_pkg;
    import idpa_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   head_id;
        logic [LINK_W-1:0] free_count;
        logic              applied;
    } t_pool_status;

    class free_list_tracker;
        logic [LINK_W-1:0] fwd[POOL_SIZE];
        logic [LINK_W-1:0] bwd[POOL_SIZE];
        bit                taken[POOL_SIZE];
        logic [LINK_W-1:0] list_head;
        logic [LINK_W-1:0] list_tail;
        logic [LINK_W-1:0] free_n;
        logic [CFG_W-1:0]  lo_id;
        logic [CFG_W-1:0]  hi_id;
        t_pool_status      awaited[$];
        int                errors;

        function new();
            foreach (fwd[i]) begin
                fwd[i]   = '0;
                bwd[i]   = '0;
                taken[i] = 1'b0;
            end
            list_head = '0;
            list_tail = '0;
            free_n    = '0;
            lo_id     = '0;
            hi_id     = CFG_W'(POOL_SIZE - 1);
            errors    = 0;
        endfunction

        function void set_range(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_FIRST_ID) begin
                lo_id = value;
            end else begin
                hi_id = value;
            end
        endfunction

        function bit id_ok(logic [ARG_W-1:0] id);
            return id >= lo_id && id <= hi_id && id < POOL_SIZE;
        endfunction

        // writes aimed at the end mark are dropped
        function void link_fwd(logic [LINK_W-1:0] idx, logic [LINK_W-1:0] value);
            if (idx < POOL_SIZE) fwd[idx[ID_W-1:0]] = value;
        endfunction

        function void take(logic [LINK_W-1:0] id);
            logic [LINK_W-1:0] p;
            logic [LINK_W-1:0] n;
            p = bwd[id[ID_W-1:0]];
            n = fwd[id[ID_W-1:0]];
            link_fwd(p, n);
            if (n < POOL_SIZE) bwd[n[ID_W-1:0]] = p;
            if (id == list_head) list_head = n;
            if (id == list_tail) list_tail = p;
            taken[id[ID_W-1:0]] = 1'b1;
            if (free_n > 0) free_n = free_n - 1'b1;
        endfunction

        function void note_request(t_cmd cmd, logic [ARG_W-1:0] arg);
            t_pool_status      st;
            int                i;
            int                k;
            logic [ID_W-1:0]   a;
            a          = arg[ID_W-1:0];
            st.applied = 1'b0;
            case (cmd)
                CMD_INIT: begin
                    foreach (taken[j]) taken[j] = 1'b0;
                    list_head = LINK_W'(lo_id);
                    list_tail = LINK_W'(hi_id);
                    if (lo_id > hi_id) begin
                        free_n = '0;
                    end else begin
                        for (i = lo_id; i <= hi_id; i++) begin
                            bwd[i] = (i == lo_id) ? END_MARK : LINK_W'(i - 1);
                            fwd[i] = (i == hi_id) ? END_MARK : LINK_W'(i + 1);
                        end
                        free_n = LINK_W'(hi_id - lo_id + 1);
                    end
                    st.applied = 1'b1;
                end
                CMD_BULK: begin
                    if (arg <= free_n) begin
                        for (k = 0; k < arg && list_head < POOL_SIZE; k++) take(list_head);
                        st.applied = 1'b1;
                    end
                end
                CMD_ALLOC: begin
                    if (id_ok(arg) && !taken[a]) begin
                        take(arg);
                        st.applied = 1'b1;
                    end
                end
                CMD_FREE: begin
                    if (id_ok(arg) && taken[a]) begin
                        // empty list: the freed id becomes head as well
                        if (free_n == 0) begin
                            list_head = arg;
                            bwd[a]    = END_MARK;
                        end else begin
                            link_fwd(list_tail, arg);
                            bwd[a] = list_tail;
                        end
                        fwd[a]    = END_MARK;
                        list_tail = arg;
                        taken[a]  = 1'b0;
                        if (free_n < POOL_SIZE) free_n = free_n + 1'b1;
                        st.applied = 1'b1;
                    end
                end
                default: ;
            endcase
            st.free_count = free_n;
            st.head_id    = (free_n == 0) ? '0 : list_head[ID_W-1:0];
            awaited.push_back(st);
        endfunction

        function void check_result(t_pool_status got);
            t_pool_status want;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding: head_id %0d free_count %0d applied %0d",
                       got.head_id, got.free_count, got.applied);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.head_id !== want.head_id) begin
                $error("head_id: expected %0d, got %0d", want.head_id, got.head_id);
                errors++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
                errors++;
            end
            if (got.applied !== want.applied) begin
                $error("applied: expected %0d, got %0d", want.applied, got.applied);
                errors++;
            end
        endfunction
    endclass
endpackage

module id_pool_free_list_allocator_core_test;
    import idpa_pkg::*;
    import idpa_test_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 28;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              result_ready = 1'b0;
    bit                steady = 1'b0;
    int                cycle_count = 0;
    free_list_tracker  tracker;

    idpa_req_if req_ch ();
    idpa_rsp_if rsp_ch ();

    assign rsp_ch.ready = result_ready;

    id_pool_free_list_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("id_pool_free_list_allocator_core_test: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result({rsp_ch.head_id, rsp_ch.free_count, rsp_ch.applied});
        end
    end

    task automatic send(t_cmd cmd, logic [ARG_W-1:0] arg);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.arg     <= arg;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.note_request(cmd, arg);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write one range register, then read it back
    task automatic program_reg(logic idx, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_range(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(value)) begin
            $error("prdata: expected %0d, got %0d", value, prdata);
            tracker.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pool(int first, int last);
        drain();
        program_reg(REG_FIRST_ID, CFG_W'(first));
        program_reg(REG_LAST_ID, CFG_W'(last));
        send(CMD_INIT, ARG_W'($urandom_range(0, 2047)));
    endtask

    // mostly an in-range id with the wanted mark, sometimes anything at all
    function automatic logic [ARG_W-1:0] pick_id(bit want_taken);
        logic [ARG_W-1:0] id;
        int               tries;
        if ($urandom_range(0, 99) < 12 || tracker.lo_id > tracker.hi_id) begin
            return ARG_W'($urandom_range(0, 2047));
        end
        id = '0;
        for (tries = 0; tries < 8; tries++) begin
            id = ARG_W'($urandom_range(tracker.lo_id, tracker.hi_id));
            if (tracker.taken[id[ID_W-1:0]] == want_taken) return id;
        end
        return id;
    endfunction

    task automatic run_random(int n);
        int r;
        int b;
        int f;
        repeat (n) begin
            r = $urandom_range(0, 99);
            b = $urandom_range(0, 99);
            f = tracker.free_n;
            if (r < 3) begin
                send(CMD_INIT, ARG_W'($urandom_range(0, 2047)));
            end else if (r < 23) begin
                // bulk sizes stay small apart from a few drains and overshoots
                if (b < 70) send(CMD_BULK, ARG_W'($urandom_range(0, (f < 6) ? f : 6)));
                else if (b < 80) send(CMD_BULK, ARG_W'(f));
                else if (b < 88) send(CMD_BULK, ARG_W'(f + 1));
                else if (b < 95) send(CMD_BULK, ARG_W'($urandom_range(0, f)));
                else send(CMD_BULK, ARG_W'($urandom_range(0, 2047)));
            end else if (r < 61) begin
                send(CMD_ALLOC, pick_id(1'b0));
            end else if (r < 97) begin
                send(CMD_FREE, pick_id(1'b1));
            end else begin
                send(t_cmd'($urandom_range(0, 3)), ARG_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    initial begin
        int first;
        int last;
        tracker        = new;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_INIT;
        req_ch.arg     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // before any init only requests that touch no links
        send(CMD_BULK, 11'd0);
        send(CMD_BULK, 11'd1);
        send(CMD_FREE, 11'd3);
        send(CMD_ALLOC, 11'd1024);
        send(CMD_ALLOC, 11'd2047);
        send(CMD_INIT, 11'd0);
        // head, tail and middle removal, then wrong marks
        send(CMD_ALLOC, 11'd0);
        send(CMD_ALLOC, 11'd1023);
        send(CMD_ALLOC, 11'd500);
        send(CMD_ALLOC, 11'd500);
        send(CMD_FREE, 11'd600);
        send(CMD_FREE, 11'd1023);
        send(CMD_FREE, 11'd0);
        send(CMD_BULK, 11'd3);
        send(CMD_BULK, 11'd1024);
        send(CMD_FREE, 11'd2047);
        send(CMD_FREE, 11'd1024);
        // drain the list, then free into an empty list
        send(CMD_BULK, tracker.free_n);
        send(CMD_FREE, 11'd10);
        send(CMD_ALLOC, 11'd10);
        send(CMD_BULK, 11'd0);
        send(CMD_BULK, 11'd1);

        set_pool(0, 1023);
        run_random(450);
        set_pool(0, 0);
        run_random(60);
        set_pool(1023, 1023);
        run_random(60);
        set_pool(1023, 0);
        run_random(40);
        steady = 1'b1;
        set_pool(0, 31);
        run_random(250);
        steady = 1'b0;
        set_pool(992, 1023);
        run_random(250);
        repeat (4) begin
            first = $urandom_range(0, 1023);
            last  = first + $urandom_range(0, 63);
            if (last > 1023) last = 1023;
            set_pool(first, last);
            run_random(150);
        end
        drain();

        if (tracker.errors == 0) begin
            $display("id_pool_free_list_allocator_core_test: PASS");
        end else begin
            $display("id_pool_free_list_allocator_core_test: FAIL");
        end
        $finish;
    end
endmodule
